### hdl/csv_style_tokenizer_defines.svh
// Assertion macros for the CSV-style tokenizer RTL.
// Included by the top level; it has no other dependencies.
`ifndef CSV_STYLE_TOKENIZER_DEFINES_SVH
`define CSV_STYLE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CST_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/csv_tok_pkg.sv
// Shared types, character codes and helpers for the CSV-style tokenizer.
// No dependencies; imported by every module of the block.
package csv_tok_pkg;

  localparam int CHAR_BITS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int CNT_BITS   = $clog2(FIFO_DEPTH + 1);

  typedef logic [CHAR_BITS-1:0]  char_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  // Character codes the lexer reacts to
  localparam char_t CH_LF     = char_t'(16'h000A);
  localparam char_t CH_CR     = char_t'(16'h000D);
  localparam char_t CH_TAB    = char_t'(16'h0009);
  localparam char_t CH_SPACE  = char_t'(16'h0020);
  localparam char_t CH_COMMA  = char_t'(16'h002C);
  localparam char_t CH_QUOTE  = char_t'(16'h0022);
  localparam char_t CH_BSLASH = char_t'(16'h005C);

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WORD   = 2'd1,
    MODE_STRING = 2'd2
  } lex_mode_e;

  typedef enum logic [1:0] {
    KIND_NEWLINE = 2'd0,
    KIND_SEP     = 2'd1,
    KIND_WORD    = 2'd2,
    KIND_STRING  = 2'd3
  } token_kind_e;

  // One tagged character on the way out
  typedef struct packed {
    token_kind_e kind;
    char_t       ch;
    logic        first;
    logic        last;
    count_t      line;
    count_t      col;
    logic        err;
    logic        last_result;
  } token_t;

  typedef struct packed {
    lex_mode_e mode;
    logic      held_valid;
  } core_status_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] count;
  } fifo_status_t;

  // Counter increment that sticks at all ones
  function automatic count_t sat_inc(input count_t v);
    return (v == '1) ? v : v + count_t'(1);
  endfunction

endpackage

### hdl/csv_style_tokenizer.sv
// Top level of the CSV-style tokenizer: lexer step plus result queue.
// Depends on csv_tok_pkg, csv_tok_core, csv_tok_fifo and csv_style_tokenizer_defines.svh.
//
// Usage: characters arrive on the s_axis stream (tdata = character, tlast = end of text).
// Each accepted request yields zero, one or two tagged characters on m_axis. A bare
// word's characters leave one request late, since a word's end is seen only at the
// following character; other tokens leave on the request that carries them.
// Output: results are registered in the result queue and leave on m_axis in order.
// Throughput: one request per cycle while the receiver keeps up; the four-entry
// result queue sets the figure, accepting whenever it has two free entries, so
// requests that yield two results can fill the queue and hold back the input.
// Stalls: when m_axis_tready is low the queue fills and s_axis_tready drops once
// fewer than two entries are free; nothing is lost.
// Reset: mode idle, queue empty, start line 1; the first character of every stream loads
// the line counter from the start line register and clears the column. The user writes
// the start line register (cfg_we_i/cfg_wdata_i) only with the stream idle; unenforced.
`include "csv_style_tokenizer_defines.svh"

module csv_style_tokenizer
  import csv_tok_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tlast,   // end_of_text
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] token_char, [16] first_of_token, [32:17] line_number, [48:33] column,
  // [49] unterminated_error, [50] last_result, [55:51] zero
  output logic [55:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [1:0] token_kind
  output logic        m_axis_tlast    // last_of_token
);

  token_t       res0, res1, head;
  logic [1:0]   push_cnt;
  logic         step;
  core_status_t core_status;
  fifo_status_t fifo_status;

  assign step = s_axis_tvalid && s_axis_tready;

  csv_tok_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .step_i     (step),
    .char_i     (char_t'(s_axis_tdata)),
    .eot_i      (s_axis_tlast),
    .res0_o     (res0),
    .res1_o     (res1),
    .push_cnt_o (push_cnt),
    .status_o   (core_status)
  );

  csv_tok_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_cnt_i(push_cnt),
    .push0_i   (res0),
    .push1_i   (res1),
    .pop_i     (m_axis_tready),
    .head_o    (head),
    .valid_o   (m_axis_tvalid),
    .ready_o   (s_axis_tready),
    .status_o  (fifo_status)
  );

  // Output packing
  assign m_axis_tdata = {5'd0, head.last_result, head.err, 16'(head.col), 16'(head.line),
                         head.first, 16'(head.ch)};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // Checks
  `CST_ASSERT_NOW(a_fifo_bound, clk_i, rst_ni, 1'b1,
    fifo_status.count <= CNT_BITS'(FIFO_DEPTH), "result queue overflow")
  `CST_ASSERT_NOW(a_err_closes_string, clk_i, rst_ni, m_axis_tvalid && head.err,
    head.last && head.kind == KIND_STRING, "open-string flag on a non-closing result")
  `CST_ASSERT_NOW(a_newline_shape, clk_i, rst_ni, m_axis_tvalid && head.kind == KIND_NEWLINE,
    head.first && head.last && head.col == '0, "malformed newline token")
  `CST_ASSERT_NEXT(a_eot_idle, clk_i, rst_ni, step && s_axis_tlast,
    core_status.mode == MODE_IDLE && !core_status.held_valid, "lexer not idle after end of text")

endmodule

### hdl/csv_tok_core.sv
// Lexer state and single-step token logic for the CSV-style tokenizer.
// Depends on csv_tok_pkg; produces up to two tagged characters per accepted request.
module csv_tok_core
  import csv_tok_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         step_i,
  input  char_t        char_i,
  input  logic         eot_i,
  output token_t       res0_o,
  output token_t       res1_o,
  output logic [1:0]   push_cnt_o,
  output core_status_t status_o
);

  count_t    start_line_q;
  lex_mode_e mode_q, mode_d;
  logic      esc_q, esc_d;
  logic      held_valid_q, held_valid_d;
  char_t     held_char_q, held_char_d;
  count_t    held_col_q, held_col_d;
  logic      held_first_q, held_first_d;
  count_t    line_q, line_d;
  count_t    colcnt_q, colcnt_d;
  logic      fresh_q;

  count_t    line_base, col, line_inc;
  logic      do_begin, is_word_char, slot1;
  logic [1:0] n;
  token_t    r0, r1, bt;
  logic      bt_emit;

  // Start-line register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_line_q <= count_t'(1);
    end else if (cfg_we_i) begin
      start_line_q <= count_t'(cfg_wdata_i);
    end
  end

  // Next state and results for one character
  always_comb begin
    line_base    = fresh_q ? start_line_q : line_q;
    col          = fresh_q ? '0 : colcnt_q;
    line_inc     = sat_inc(line_base);
    colcnt_d     = sat_inc(col);
    line_d       = line_base;
    mode_d       = mode_q;
    esc_d        = esc_q;
    held_valid_d = held_valid_q;
    held_char_d  = held_char_q;
    held_col_d   = held_col_q;
    held_first_d = held_first_q;
    is_word_char = (char_i != CH_QUOTE) && (char_i != CH_COMMA) &&
                   (char_i != CH_LF) && (char_i != CH_CR);
    do_begin     = 1'b0;
    n            = 2'd0;
    r0           = '0;
    r1           = '0;
    bt           = '0;
    bt_emit      = 1'b0;

    if (mode_q == MODE_WORD && held_valid_q) begin
      // held word character goes out now
      r0.kind  = KIND_WORD;
      r0.ch    = held_char_q;
      r0.first = held_first_q;
      r0.line  = line_base;
      r0.col   = held_col_q;
      n        = 2'd1;
      if (is_word_char) begin
        if (eot_i) begin
          r1.kind  = KIND_WORD;
          r1.ch    = char_i;
          r1.last  = 1'b1;
          r1.line  = line_base;
          r1.col   = col;
          n        = 2'd2;
          held_valid_d = 1'b0;
          mode_d       = MODE_IDLE;
        end else begin
          held_char_d  = char_i;
          held_col_d   = col;
          held_first_d = 1'b0;
        end
      end else begin
        r0.last      = 1'b1;
        held_valid_d = 1'b0;
        mode_d       = MODE_IDLE;
        do_begin     = 1'b1;
      end
    end else if (mode_q == MODE_STRING) begin
      // string body with backslash escapes
      r0.kind = KIND_STRING;
      r0.ch   = char_i;
      r0.line = line_base;
      r0.col  = col;
      n       = 2'd1;
      if (char_i == CH_BSLASH && !esc_q) begin
        esc_d = 1'b1;
      end else if (char_i == CH_QUOTE && !esc_q) begin
        r0.last = 1'b1;
        mode_d  = MODE_IDLE;
        esc_d   = 1'b0;
      end else begin
        esc_d = 1'b0;
      end
      if (mode_d == MODE_STRING && eot_i) begin
        r0.last = 1'b1;
        r0.err  = 1'b1;
      end
    end else begin
      mode_d       = MODE_IDLE;
      held_valid_d = 1'b0;
      do_begin     = 1'b1;
    end

    // token opening
    if (do_begin) begin
      bt.ch   = char_i;
      bt.line = line_base;
      bt.col  = col;
      if (char_i == CH_LF) begin
        bt.kind  = KIND_NEWLINE;
        bt.first = 1'b1;
        bt.last  = 1'b1;
        bt.line  = line_inc;
        bt.col   = '0;
        bt_emit  = 1'b1;
        line_d   = line_inc;
        colcnt_d = count_t'(1);
      end else if (char_i == CH_SPACE || char_i == CH_TAB || char_i == CH_CR) begin
        bt_emit = 1'b0;
      end else if (char_i == CH_COMMA) begin
        bt.kind  = KIND_SEP;
        bt.first = 1'b1;
        bt.last  = 1'b1;
        bt_emit  = 1'b1;
      end else if (char_i == CH_QUOTE) begin
        bt.kind  = KIND_STRING;
        bt.first = 1'b1;
        bt.last  = eot_i;
        bt.err   = eot_i;
        bt_emit  = 1'b1;
        mode_d   = MODE_STRING;
        esc_d    = 1'b0;
      end else if (eot_i) begin
        bt.kind  = KIND_WORD;
        bt.first = 1'b1;
        bt.last  = 1'b1;
        bt_emit  = 1'b1;
      end else begin
        mode_d       = MODE_WORD;
        held_valid_d = 1'b1;
        held_char_d  = char_i;
        held_col_d   = col;
        held_first_d = 1'b1;
      end
      if (bt_emit) begin
        if (n == 2'd0) begin
          r0 = bt;
        end else begin
          r1 = bt;
        end
        n = n + 2'd1;
      end
    end

    // end of stream closes everything
    if (eot_i) begin
      mode_d       = MODE_IDLE;
      esc_d        = 1'b0;
      held_valid_d = 1'b0;
    end

    slot1 = (n == 2'd2);
    if (slot1) begin
      r1.last_result = 1'b1;
    end else if (n == 2'd1) begin
      r0.last_result = 1'b1;
    end
  end

  // State registers, updated on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_IDLE;
      esc_q        <= 1'b0;
      held_valid_q <= 1'b0;
      held_char_q  <= '0;
      held_col_q   <= '0;
      held_first_q <= 1'b0;
      line_q       <= count_t'(1);
      colcnt_q     <= '0;
      fresh_q      <= 1'b1;
    end else if (step_i) begin
      mode_q       <= mode_d;
      esc_q        <= esc_d;
      held_valid_q <= held_valid_d;
      held_char_q  <= held_char_d;
      held_col_q   <= held_col_d;
      held_first_q <= held_first_d;
      line_q       <= line_d;
      colcnt_q     <= colcnt_d;
      fresh_q      <= eot_i;
    end
  end

  assign res0_o     = r0;
  assign res1_o     = r1;
  assign push_cnt_o = step_i ? n : 2'd0;

  assign status_o.mode       = mode_q;
  assign status_o.held_valid = held_valid_q;

endmodule

### hdl/csv_tok_fifo.sv
// Result queue for the CSV-style tokenizer: takes up to two entries, gives one per cycle while pop_i is high.
// Depends on csv_tok_pkg.
module csv_tok_fifo
  import csv_tok_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic [1:0]   push_cnt_i,
  input  token_t       push0_i,
  input  token_t       push1_i,
  input  logic         pop_i,
  output token_t       head_o,
  output logic         valid_o,
  output logic         ready_o,
  output fifo_status_t status_o
);

  token_t              mem_q [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_p1;
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                pop;

  assign pop       = pop_i && valid_o;
  assign wr_ptr_p1 = wr_ptr_q + PTR_BITS'(1);

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_BITS'(push_cnt_i);
    rd_ptr_d = rd_ptr_q + PTR_BITS'(pop);
    cnt_d    = cnt_q + CNT_BITS'(push_cnt_i) - CNT_BITS'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_ptr_p1] <= push1_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign valid_o        = (cnt_q != '0);
  assign ready_o        = (cnt_q <= CNT_BITS'(FIFO_DEPTH - 2));
  assign status_o.count = cnt_q;

endmodule
